// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CBC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define CBC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`CBC_ASSERT(lbl, clk, rstn, !(cond), msg)

`else

`define CBC_ASSERT(lbl, clk, rstn, prop, msg)

`define CBC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/core/cbc_pkg.sv
package cbc_pkg;

	localparam int ROM_BANKS_DEF = 512;
	localparam int RAM_BANKS_DEF = 16;

	localparam int ROM_BANK_W = 9;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int PA_W       = 23;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 24;
	localparam int M_FIELDS_W = 45;
	localparam int M_TDATA_W  = 48;

	// mapper kinds
	localparam logic [2:0] MAP_ROM_ONLY = 3'd0;
	localparam logic [2:0] MAP_MBC1     = 3'd1;
	localparam logic [2:0] MAP_MBC2     = 3'd2;
	localparam logic [2:0] MAP_MBC3     = 3'd3;
	localparam logic [2:0] MAP_MBC5     = 3'd4;

	// result targets
	localparam logic [1:0] TGT_CONST = 2'd0;
	localparam logic [1:0] TGT_ROM   = 2'd1;
	localparam logic [1:0] TGT_RAM   = 2'd2;
	localparam logic [1:0] TGT_RTC   = 2'd3;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAPPER    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES = 2'd3;

	// bus map
	localparam logic [ADDR_W-1:0] ADDR_RAM_EN_END  = 16'h2000;
	localparam logic [ADDR_W-1:0] ADDR_ROM_HI_SEL  = 16'h3000;
	localparam logic [ADDR_W-1:0] ADDR_BANK_AREA   = 16'h4000;
	localparam logic [ADDR_W-1:0] ADDR_RAM_SEL_END = 16'h6000;
	localparam logic [ADDR_W-1:0] ADDR_ROM_END     = 16'h8000;

	localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;
	localparam logic [DATA_W-1:0] RTC_FIRST  = 8'h08;
	localparam logic [DATA_W-1:0] RTC_LAST   = 8'h0C;
	localparam logic [DATA_W-1:0] MBC3_RAM_LAST = 8'h03;

	typedef struct packed {
		logic capture;
		logic red_start;
		logic red_step;
		logic commit;
	} cbc_cmd_t;

	typedef struct packed {
		logic wrap_needed;
		logic slot_free;
	} cbc_status_t;

endpackage

// File: rtl/core/cbc_ctrl.sv
`include "assert_macros.svh"

module cbc_ctrl import cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cbc_status_t sts,
	output cbc_cmd_t    cmd
);

	localparam int CW = $clog2(ROM_BANK_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REDUCE,
		ST_COMMIT
	} state_t;

	state_t        state_q;
	logic          ready_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
						ready_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (sts.wrap_needed) begin
						state_q <= ST_REDUCE;
						cnt_q   <= '0;
					end else if (sts.slot_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= ST_COMMIT;
					end
				end
				ST_REDUCE: begin
					if (cnt_q == CW'(ROM_BANK_W - 1)) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					if (sts.slot_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

	always_comb begin
		cmd.capture   = ready_q && in_valid;
		cmd.red_start = (state_q == ST_EVAL) && sts.wrap_needed;
		cmd.red_step  = (state_q == ST_REDUCE);
		cmd.commit    = sts.slot_free &&
			(((state_q == ST_EVAL) && !sts.wrap_needed) || (state_q == ST_COMMIT));
	end

	`CBC_ASSERT(a_start_then_step, clk, arst_n, cmd.red_start |=> cmd.red_step, "no step after start")
	`CBC_ASSERT(a_reduce_len, clk, arst_n, cmd.red_start |-> ##(ROM_BANK_W + 1) (state_q == ST_COMMIT), "bad reduce length")
	`CBC_ASSERT(a_commit_to_idle, clk, arst_n, cmd.commit |=> in_ready, "not ready after commit")

endmodule

// File: rtl/core/cbc_datapath.sv
module cbc_datapath import cbc_pkg::*; #(
	parameter int MAX_ROM_BANKS = ROM_BANKS_DEF,
	parameter int MAX_RAM_BANKS = RAM_BANKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbc_cmd_t             cmd,
	output cbc_status_t          sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [1:0]           m_tuser
);

	localparam int RW  = $clog2(MAX_ROM_BANKS);
	localparam int NW  = RW + 1;
	localparam int RBW = $clog2(MAX_RAM_BANKS + 1);
	localparam int RIW = (MAX_RAM_BANKS > 1) ? $clog2(MAX_RAM_BANKS) : 1;

	logic [2:0]            mapper_q;
	logic [9:0]            rom_count_q;
	logic [4:0]            ram_count_q;
	logic [23:0]           rom_bytes_q;
	logic                  ram_enable_q;
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [7:0]            ram_bank_q;
	logic                  bank_mode_q;

	logic              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;

	logic [RW-1:0]         rem_q;
	logic [ROM_BANK_W-1:0] div_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_tdata_q;
	logic [1:0]           out_tuser_q;

	logic [NW-1:0]         n_eff;
	logic [RBW-1:0]        ram_lim;
	logic [ROM_BANK_W-1:0] ub;
	logic                  ub_ge_n;
	logic [RW-1:0]         bank_mod;
	logic [PA_W-1:0]       rom_pa;
	logic [NW-1:0]         part;
	logic [RW-1:0]         rem_next;
	logic                  mbc;
	logic                  in_ram;

	logic [1:0]      r_kind;
	logic [PA_W-1:0] r_pa;
	logic [2:0]      r_reg;
	logic            r_nib;
	logic [7:0]      r_bank;
	logic            r_chk;

	logic [1:0]        res_target;
	logic [PA_W-1:0]   res_pa;
	logic [7:0]        res_cv;
	logic              res_nib;
	logic              res_ramw;
	logic [DATA_W-1:0] res_wd;
	logic [2:0]        res_reg;
	logic              res_rtcw;

	// bank counts as seen by the mapping
	always_comb begin
		if (rom_count_q > 10'(MAX_ROM_BANKS)) begin
			n_eff = NW'(MAX_ROM_BANKS);
		end else if (rom_count_q == '0) begin
			n_eff = NW'(1);
		end else begin
			n_eff = NW'(rom_count_q);
		end
		if (ram_count_q > 5'(MAX_RAM_BANKS)) begin
			ram_lim = RBW'(MAX_RAM_BANKS);
		end else begin
			ram_lim = RBW'(ram_count_q);
		end
	end

	assign mbc    = (mapper_q >= MAP_MBC1) && (mapper_q <= MAP_MBC5);
	assign in_ram = (addr_q[15:13] == 3'b101);

	// bank selected for the switchable rom window
	always_comb begin
		case (mapper_q)
			MAP_MBC1: begin
				ub = {2'b00, (bank_mode_q ? 2'b00 : ram_bank_q[1:0]), rom_bank_q[4:0]};
				if (rom_bank_q[4:0] == 5'd0) begin
					ub[0] = 1'b1;
				end
			end
			MAP_MBC2: begin
				ub = {1'b0, rom_bank_q[7:0]};
				if (rom_bank_q[7:0] == 8'd0) begin
					ub = 9'd1;
				end
			end
			MAP_MBC3: begin
				ub = {2'b00, rom_bank_q[6:0]};
				if (rom_bank_q[6:0] == 7'd0) begin
					ub = 9'd1;
				end
			end
			default: ub = rom_bank_q;
		endcase
	end

	assign ub_ge_n  = (10'(ub) >= 10'(n_eff));
	assign bank_mod = ub_ge_n ? rem_q : RW'(ub);
	assign rom_pa   = {9'(bank_mod), addr_q[13:0]};

	// one restoring remainder step per cycle, msb of the bank first
	assign part     = {rem_q, div_q[ROM_BANK_W-1]};
	assign rem_next = (part >= n_eff) ? RW'(part - n_eff) : RW'(part);

	// cartridge ram window routing
	always_comb begin
		r_kind = TGT_CONST;
		r_pa   = '0;
		r_reg  = '0;
		r_nib  = 1'b0;
		r_bank = '0;
		r_chk  = 1'b0;
		if (ram_enable_q) begin
			case (mapper_q)
				MAP_MBC1: begin
					r_bank = bank_mode_q ? ram_bank_q : 8'd0;
					r_chk  = 1'b1;
				end
				MAP_MBC2: begin
					r_kind = TGT_RAM;
					r_pa   = PA_W'(addr_q[8:0]);
					r_nib  = 1'b1;
				end
				MAP_MBC3: begin
					if (ram_bank_q > MBC3_RAM_LAST) begin
						if (ram_bank_q inside {[RTC_FIRST:RTC_LAST]}) begin
							r_kind = TGT_RTC;
							r_reg  = 3'(ram_bank_q - RTC_FIRST);
						end
					end else begin
						r_bank = ram_bank_q;
						r_chk  = 1'b1;
					end
				end
				MAP_MBC5: begin
					r_bank = ram_bank_q;
					r_chk  = 1'b1;
				end
				default: ;
			endcase
			if (r_chk && (r_bank < 8'(ram_lim))) begin
				r_kind = TGT_RAM;
				r_pa   = PA_W'({r_bank[RIW-1:0], addr_q[12:0]});
			end
		end
	end

	always_comb begin
		res_target = TGT_CONST;
		res_pa     = '0;
		res_cv     = 8'h00;
		res_nib    = 1'b0;
		res_ramw   = 1'b0;
		res_wd     = '0;
		res_reg    = '0;
		res_rtcw   = 1'b0;
		if (cmd_q == CMD_READ) begin
			if (addr_q < ADDR_BANK_AREA) begin
				if (24'(addr_q) < rom_bytes_q) begin
					res_target = TGT_ROM;
					res_pa     = PA_W'(addr_q);
				end
			end else if (mapper_q == MAP_ROM_ONLY) begin
				if ((addr_q < ADDR_ROM_END) && (24'(addr_q) < rom_bytes_q)) begin
					res_target = TGT_ROM;
					res_pa     = PA_W'(addr_q);
				end else begin
					res_cv = 8'hFF;
				end
			end else if (!mbc) begin
				res_cv = 8'h00;
			end else if (addr_q < ADDR_ROM_END) begin
				res_target = TGT_ROM;
				res_pa     = rom_pa;
			end else if (in_ram) begin
				if (r_kind == TGT_CONST) begin
					res_cv = 8'hFF;
				end else begin
					res_target = r_kind;
					res_pa     = r_pa;
					res_reg    = r_reg;
					res_nib    = r_nib;
				end
			end else begin
				res_cv = 8'hFF;
			end
		end else if (mbc && in_ram) begin
			if (r_kind == TGT_RAM) begin
				res_target = TGT_RAM;
				res_pa     = r_pa;
				res_ramw   = 1'b1;
				res_wd     = r_nib ? {4'h0, data_q[3:0]} : data_q;
			end else if (r_kind == TGT_RTC) begin
				res_target = TGT_RTC;
				res_reg    = r_reg;
				res_rtcw   = 1'b1;
			end
		end
	end

	assign sts.wrap_needed = (cmd_q == CMD_READ) && mbc && (addr_q[15:14] == 2'b01) && ub_ge_n;
	assign sts.slot_free   = !out_valid_q || m_tready;

	// configuration and bank registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_q     <= MAP_ROM_ONLY;
			rom_count_q  <= 10'd2;
			ram_count_q  <= 5'd0;
			rom_bytes_q  <= 24'h008000;
			ram_enable_q <= 1'b0;
			rom_bank_q   <= '0;
			ram_bank_q   <= '0;
			bank_mode_q  <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_MAPPER: begin
					mapper_q     <= cfg_data[2:0];
					ram_enable_q <= 1'b0;
					rom_bank_q   <= (cfg_data[2:0] == MAP_MBC5) ? 9'd1 : 9'd0;
					ram_bank_q   <= '0;
					bank_mode_q  <= 1'b0;
				end
				CFG_ROM_BANKS: rom_count_q <= cfg_data[9:0];
				CFG_RAM_BANKS: ram_count_q <= cfg_data[4:0];
				CFG_ROM_BYTES: rom_bytes_q <= cfg_data[23:0];
				default: ;
			endcase
		end else if (cmd.commit && (cmd_q == CMD_WRITE) && mbc && !in_ram) begin
			if (addr_q < ADDR_RAM_EN_END) begin
				if (mapper_q == MAP_MBC5) begin
					ram_enable_q <= (data_q == RAM_EN_KEY);
				end else begin
					ram_enable_q <= (data_q[3:0] == RAM_EN_KEY[3:0]);
				end
			end else if (addr_q < ADDR_BANK_AREA) begin
				case (mapper_q)
					MAP_MBC1: rom_bank_q <= {4'b0000, data_q[4:0]};
					MAP_MBC2: rom_bank_q <= {1'b0, data_q};
					MAP_MBC3: rom_bank_q <= {2'b00, data_q[6:0]};
					default: begin
						// mbc5 splits the bank number over two write areas
						if (addr_q < ADDR_ROM_HI_SEL) begin
							rom_bank_q <= {rom_bank_q[8], data_q};
						end else begin
							rom_bank_q <= {data_q[0], rom_bank_q[7:0]};
						end
					end
				endcase
			end else if (addr_q < ADDR_RAM_SEL_END) begin
				if (mapper_q == MAP_MBC1) begin
					ram_bank_q <= {6'b000000, data_q[1:0]};
				end else if (mapper_q != MAP_MBC2) begin
					ram_bank_q <= data_q;
				end
			end else if (addr_q < ADDR_ROM_END) begin
				if (mapper_q == MAP_MBC1) begin
					bank_mode_q <= data_q[0];
				end
			end
		end
	end

	// held access and remainder unit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= s_tuser[0];
			addr_q <= s_tdata[15:0];
			data_q <= s_tdata[23:16];
		end
		if (cmd.red_start) begin
			rem_q <= '0;
			div_q <= ub;
		end else if (cmd.red_step) begin
			rem_q <= rem_next;
			div_q <= {div_q[ROM_BANK_W-2:0], 1'b0};
		end
		if (cmd.commit) begin
			out_tdata_q <= {{(M_TDATA_W - M_FIELDS_W){1'b0}}, res_rtcw, res_reg, res_wd,
				res_ramw, res_nib, res_cv, res_pa};
			out_tuser_q <= res_target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_tuser_q;

endmodule

// File: rtl/core/cartridge_bank_controller_unit.sv
// Cartridge bank mapper: each input beat is one CPU bus access (read or write, address, byte)
// and yields one output beat saying where it lands - a ROM or cartridge RAM byte address, an
// RTC register, or a constant 0x00/0xFF read value - for ROM-only, MBC1, MBC2, MBC3 and MBC5
// cartridges, while control-area writes on the MBC types update the RAM-enable, ROM bank, RAM
// bank and mode registers. An access is evaluated in the cycle after acceptance and, with a
// free output register, reaches the result register at the end of that cycle, after which
// the next access can be taken. A read of the switchable ROM window whose bank number is at
// or above the configured bank count first has its bank reduced by a restoring remainder unit
// that handles one bank bit per cycle, all nine of them, and then reaches the result register
// from the commit state. The next access is accepted while a finished result still waits in
// the output register; its own result then waits until that register frees. Configuration
// writes belong to idle periods; writing the mapper type returns the bank registers to that
// type's reset values.
module cartridge_bank_controller_unit import cbc_pkg::*; #(
	parameter int MAX_ROM_BANKS = ROM_BANKS_DEF,
	parameter int MAX_RAM_BANKS = RAM_BANKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // address[15:0], data[23:16]
	input  logic [0:0]           s_tuser,   // cmd[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// physical_address[22:0], constant_value[30:23], nibble_only[31], ram_write[32],
	// write_data[40:33], rtc_register[43:41], rtc_wr[44], zero[47:45]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [1:0]           m_tuser,   // target[1:0]
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cbc_cmd_t    cmd;
	cbc_status_t sts;

	cbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbc_datapath #(
		.MAX_ROM_BANKS (MAX_ROM_BANKS),
		.MAX_RAM_BANKS (MAX_RAM_BANKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
